// ===== rtl/dma_ring_receive_reader_macros.svh =====
// Assertion macros shared by the checker of the receive ring reader.
// Depends on nothing; the user supplies a clock i_clk and reset i_rst_n.
`ifndef DMA_RING_RECEIVE_READER_MACROS_SVH
`define DMA_RING_RECEIVE_READER_MACROS_SVH

// same-cycle implication
`define DRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drr check failed");

// next-cycle implication
`define DRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drr check failed");

`endif

// ===== rtl/drr_pkg.sv =====
// Shared constants for the receive ring reader: opcodes, field widths, stream layout.
// No dependencies.
package drr_pkg;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_WRAP  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int REM_W    = 9;
    localparam int LEVEL_W  = 9;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 1;

    // passes kept free below the top of the count range before folding
    localparam int RENORM_MARGIN = 10;

endpackage

// ===== rtl/dma_ring_receive_reader.sv =====
// Reader for a receive ring filled by a down-counting DMA. One item is accepted per clock
// while the output is not stalled: it lands in an input register, all count and pointer
// updates are done in one pass from there, and a pop's result (byte read from the ring RAM's
// registered port) lands in the output register. Stores and wrap items give no result. The
// rate is one item per cycle, set by the single read and single write port of the ring RAM
// and the input/output register pair; output backpressure stalls the input register, never
// drops anything. DEPTH must be a power of two. No clearing pass after reset.
module dma_ring_receive_reader #(
    parameter int DEPTH      = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] store_index, [15:8] store_byte, [24:16] dma_remaining, rest zero
    input  logic [drr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [drr_pkg::S_USER_W-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data_byte, [8] overrun_seen, [17:9] unread_after, [26:18] peak_fill, rest zero
    output logic [drr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [0] byte_valid
    output logic [drr_pkg::M_USER_W-1:0]  m_axis_tuser
);
    import drr_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int DB = $clog2(DEPTH);
    localparam int RW = (REM_W > DB + 1) ? REM_W : DB + 1;
    localparam logic [CB-1:0] LIM      = {CB{1'b1}} >> DB;
    localparam logic [CB-1:0] LOW_MASK = CB'(DEPTH - 1);
    localparam logic [CB-1:0] DEP_C    = CB'(DEPTH);

    // input register
    logic               r_in_valid;
    logic [OP_W-1:0]    r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [BYTE_W-1:0]  r_byte;
    logic [REM_W-1:0]   r_rem;

    // reader state
    logic [CB-1:0]      r_pass;
    logic [CB-1:0]      r_last_pass;
    logic [CB-1:0]      r_rd_count;
    logic [DB-1:0]      r_rd_pos;
    logic               r_overrun;
    logic [DB:0]        r_peak;

    // output register
    logic               r_out_valid;
    logic               r_byte_valid;
    logic [LEVEL_W-1:0] r_unread;
    logic [LEVEL_W-1:0] r_peak_out;
    logic               r_overrun_out;

    logic               adv;
    logic               fire;
    logic               is_pop;
    logic [RW-1:0]      rem_w;
    logic               refuse;
    logic               mid;
    logic               renorm_due;
    logic [CB-1:0]      whole;
    logic [CB-1:0]      pass_n;
    logic [CB-1:0]      rc_n;
    logic [CB-1:0]      head;
    logic [CB-1:0]      wpos;
    logic [CB-1:0]      unread;
    logic               over;
    logic [DB:0]        unread_c;
    logic [CB-1:0]      rc_o;
    logic [DB-1:0]      pos_o;
    logic               has;
    logic               commit;
    logic [BYTE_W-1:0]  rd_data;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign fire          = r_in_valid && adv;
    assign is_pop        = (r_op == OP_POP);

    always_comb begin
        rem_w  = RW'(r_rem);
        refuse = (r_pass == r_last_pass) && ((rem_w == '0) || (rem_w >= RW'(DEPTH)));
        mid    = (rem_w > RW'(1)) && (rem_w < RW'(DEPTH - 1));

        // fold whole passes out of both counters before the pass count runs out
        renorm_due = (r_pass + CB'(RENORM_MARGIN)) > LIM;
        whole      = r_pass << DB;
        pass_n     = r_pass;
        rc_n       = r_rd_count;
        if (renorm_due) begin
            if (r_rd_count < whole) begin
                pass_n = r_pass - (r_rd_count >> DB);
                rc_n   = r_rd_count & LOW_MASK;
            end else begin
                pass_n = '0;
                rc_n   = r_rd_count - whole;
            end
        end

        head   = DEP_C - CB'(r_rem);
        wpos   = (pass_n << DB) + head;
        unread = wpos - rc_n;
        over   = {1'b0, unread} > (CB + 1)'(DEPTH);

        // overrun: keep only the newest DEPTH bytes
        if (over) begin
            unread_c = (DB + 1)'(DEPTH);
            rc_o     = wpos - DEP_C;
            pos_o    = head[DB-1:0] + DB'(1);
        end else begin
            unread_c = unread[DB:0];
            rc_o     = rc_n;
            pos_o    = r_rd_pos;
        end
        has    = (unread_c != '0);
        commit = fire && is_pop && !refuse;
    end

    drr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (BYTE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fire && (r_op == OP_STORE)),
        .i_wr_addr (DB'(r_idx)),
        .i_wr_data (r_byte),
        .i_rd_en   (fire && is_pop),
        .i_rd_addr (pos_o),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_op   <= s_axis_tuser[OP_W-1:0];
            r_idx  <= s_axis_tdata[IDX_W-1:0];
            r_byte <= s_axis_tdata[IDX_W +: BYTE_W];
            r_rem  <= s_axis_tdata[IDX_W + BYTE_W +: REM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass      <= '0;
            r_last_pass <= '0;
            r_rd_count  <= '0;
            r_rd_pos    <= '0;
            r_overrun   <= 1'b0;
            r_peak      <= '0;
        end else if (fire && (r_op == OP_WRAP)) begin
            r_pass <= r_pass + CB'(1);
        end else if (commit) begin
            if (mid) begin
                r_last_pass <= r_pass;
            end
            r_pass     <= pass_n;
            r_rd_count <= has ? rc_o + CB'(1) : rc_o;
            r_rd_pos   <= has ? pos_o + DB'(1) : pos_o;
            if (over) begin
                r_overrun <= 1'b1;
            end
            if (has && (unread_c >= r_peak)) begin
                r_peak <= unread_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && is_pop;
        end
        if (fire && is_pop) begin
            r_byte_valid  <= !refuse && has;
            r_unread      <= (!refuse && has) ? LEVEL_W'(unread_c - (DB + 1)'(1)) : '0;
            r_overrun_out <= r_overrun || (!refuse && over);
            r_peak_out    <= (!refuse && has && (unread_c >= r_peak)) ? LEVEL_W'(unread_c)
                                                                      : LEVEL_W'(r_peak);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = M_USER_W'(r_byte_valid);
    assign m_axis_tdata  = M_DATA_W'({r_peak_out, r_unread, r_overrun_out,
                                      r_byte_valid ? rd_data : {BYTE_W{1'b0}}});

endmodule

// ===== rtl/drr_ram.sv =====
// Ring byte storage: one write port, one registered read port.
// Depends on nothing.
module drr_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/drr_checker.sv =====
// Port-level checks for the receive ring reader, bound to the top level.
// Depends on drr_pkg and dma_ring_receive_reader_macros.svh.
`include "dma_ring_receive_reader_macros.svh"

module drr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [drr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic [drr_pkg::M_USER_W-1:0]  m_axis_tuser
);
    import drr_pkg::*;

    // a stalled result holds
    `DRR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an empty or refused pop carries no byte and no unread count
    `DRR_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0],
        (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[17:9] == 9'd0))

    // the overrun flag never clears between back-to-back results
    `DRR_ASSERT_NEXT(a_overrun_sticky, m_axis_tvalid && m_axis_tready && m_axis_tdata[8],
        !m_axis_tvalid || m_axis_tdata[8])

    // ready toward the source never drops while the result side is free
    `DRR_ASSERT_NOW(a_ready_free, !m_axis_tvalid, s_axis_tready)

endmodule

bind dma_ring_receive_reader drr_checker u_drr_checker (.*);
